### rtl/core/double_ended_queue_core_defines.svh
// Assertion macros shared by the deque core checker.
// No dependencies; include by bare file name.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define DQ_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that holds at every edge, reset included.
`define DQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/dq_pkg.sv
// Package for the deque core: sizes, request and result word types,
// action and status codes and ring pointer helpers. No dependencies.
package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PUSH_HEAD = 2'd0,
    ACT_PUSH_TAIL = 2'd1,
    ACT_POP_HEAD  = 2'd2,
    ACT_POP_TAIL  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NULL      = 2'd3
  } status_t;

  typedef struct packed {
    action_t               action;
    logic [ITEM_WIDTH-1:0] item;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [ITEM_WIDTH-1:0] popped_item;
    logic [CNT_W-1:0]      count;
  } rsp_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

### rtl/core/double_ended_queue_core.sv
// Deque core: a bounded double-ended queue kept in a ring memory.
// The result word appears in the cycle after its request is accepted.
// Throughput: one request per cycle; busy stays low, so start may be held high.
// The pace is set by the single-port slot memory, touched once per request.
// Reset (rst, synchronous, active high) empties the queue; slot contents
// are left as they are, since a pop only ever reads a slot a push wrote.
module double_ended_queue_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  dq_pkg::req_t request,
  output logic         done,
  output dq_pkg::rsp_t result
);
  import dq_pkg::*;

  // Ring state. head points at the head item, tail one past the tail item.
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] occupancy;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic [CNT_W-1:0] occupancy_next;

  // Slot memory with a registered read port.
  logic [ITEM_WIDTH-1:0] slots [DEPTH];
  logic [ITEM_WIDTH-1:0] rd_data;

  logic             accept;
  logic             wr_en;
  logic             rd_en;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rd_addr;
  status_t          status_next;

  // Registered result fields; popped_item comes from the memory read register.
  status_t          status_q;
  logic [CNT_W-1:0] count_q;
  logic             pop_ok;

  // Every request needs at most one memory access, so the core never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decide the outcome of the request and the pointer moves.
  always_comb begin
    head_next      = head;
    tail_next      = tail;
    occupancy_next = occupancy;
    status_next    = ST_OK;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_addr        = tail;
    rd_addr        = head;
    case (request.action)
      ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
        // The null check wins over the full check.
        if (request.item == '0) begin
          status_next = ST_NULL;
        end else if (occupancy == CNT_W'(DEPTH)) begin
          status_next = ST_OVERFLOW;
        end else begin
          wr_en          = 1'b1;
          occupancy_next = occupancy + 1'b1;
          if (request.action == ACT_PUSH_HEAD) begin
            head_next = ring_prev(head);
            wr_addr   = ring_prev(head);
          end else begin
            wr_addr   = tail;
            tail_next = ring_next(tail);
          end
        end
      end
      ACT_POP_HEAD, ACT_POP_TAIL: begin
        if (occupancy == '0) begin
          status_next = ST_UNDERFLOW;
        end else begin
          rd_en          = 1'b1;
          occupancy_next = occupancy - 1'b1;
          if (request.action == ACT_POP_HEAD) begin
            rd_addr   = head;
            head_next = ring_next(head);
          end else begin
            tail_next = ring_prev(tail);
            rd_addr   = ring_prev(tail);
          end
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // A pop right after a push to the same slot is safe: the write lands at
  // the edge that ends the push cycle, before the pop reads.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      slots[wr_addr] <= request.item;
    end
    if (accept && rd_en) begin
      rd_data <= slots[rd_addr];
    end
  end

  // Control state and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      done      <= 1'b0;
      pop_ok    <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        head      <= head_next;
        tail      <= tail_next;
        occupancy <= occupancy_next;
        pop_ok    <= rd_en;
      end
    end
  end

  // Result payload needs no reset; it is only looked at under done.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      count_q  <= occupancy_next;
    end
  end

  assign result.status      = status_q;
  assign result.popped_item = pop_ok ? rd_data : '0;
  assign result.count       = count_q;

endmodule

### rtl/core/dq_checker.sv
// Port-level checker for the deque core, bound to double_ended_queue_core.
// Depends on dq_pkg and double_ended_queue_core_defines.svh.
`include "double_ended_queue_core_defines.svh"

module dq_checker (
  input logic         clk,
  input logic         rst,
  input logic         start,
  input logic         busy,
  input dq_pkg::req_t request,
  input logic         done,
  input dq_pkg::rsp_t result
);
  import dq_pkg::*;

  `DQ_ASSERT_RST(a_done_follows_accept, clk, rst, (start && !busy) |=> done, "missing result word")
  `DQ_ASSERT_RST(a_no_spurious_done, clk, rst, !(start && !busy) |=> !done, "unrequested result word")
  `DQ_ASSERT_RST(a_failed_pops_zero, clk, rst, (done && result.status != ST_OK) |-> (result.popped_item == '0), "failed step returned an item")
  `DQ_ASSERT_RST(a_underflow_empty, clk, rst, (done && result.status == ST_UNDERFLOW) |-> (result.count == '0), "underflow with items held")
  `DQ_ASSERT_RST(a_overflow_full, clk, rst, (done && result.status == ST_OVERFLOW) |-> (result.count == CNT_W'(DEPTH)), "overflow below full")

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);
